// File: hw/rtl/onewire_temperature_read_master_unit_assert.svh
// assertion macros used by the checker file of the 1-wire temperature master
// depends on clk and rst_n being visible where a macro is used
`ifndef ONEWIRE_TEMPERATURE_READ_MASTER_UNIT_ASSERT_SVH
`define ONEWIRE_TEMPERATURE_READ_MASTER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define OWTRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define OWTRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/owtrm_pkg.sv
// types, register map and constants of the 1-wire temperature read master
// no dependencies; used by the top level and its checker
package owtrm_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 20;

    // input transaction: kind and sampled bus level
    typedef struct packed {
        logic kind;
        logic line_in;
    } req_t;

    // result transaction
    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        logic        no_device;
        logic [11:0] temperature;
    } rsp_t;

    // item kinds
    localparam logic KIND_TICK  = 1'b0;
    localparam logic KIND_START = 1'b1;

    // register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_RESET_TAIL    = 3'd2,
        REG_CONV_WAIT     = 3'd3,
        REG_SLOT_START    = 3'd4,
        REG_WRITE_SLOT    = 3'd5,
        REG_READ_SAMPLE   = 3'd6,
        REG_READ_TAIL     = 3'd7
    } reg_idx_t;

    // timing registers
    typedef struct packed {
        logic [9:0]       reset_low;
        logic [7:0]       presence_wait;
        logic [9:0]       reset_tail;
        logic [CNT_W-1:0] conv_wait;
        logic [3:0]       slot_start;
        logic [6:0]       write_slot;
        logic [5:0]       read_sample;
        logic [6:0]       read_tail;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        reset_low:     10'd480,
        presence_wait: 8'd60,
        reset_tail:    10'd420,
        conv_wait:     20'd200000,
        slot_start:    4'd2,
        write_slot:    7'd60,
        read_sample:   6'd10,
        read_tail:     7'd50
    };

    // bus commands
    localparam logic [7:0] CMD_SKIP_ROM  = 8'hCC;
    localparam logic [7:0] CMD_CONVERT   = 8'h44;
    localparam logic [7:0] CMD_READ_SPAD = 8'hBE;

    // sequence phases, one-hot
    typedef enum logic [11:0] {
        PH_IDLE       = 12'b0000_0000_0001,
        PH_RST_LOW    = 12'b0000_0000_0010,
        PH_RST_WAIT   = 12'b0000_0000_0100,
        PH_RST_SAMPLE = 12'b0000_0000_1000,
        PH_RST_TAIL   = 12'b0000_0001_0000,
        PH_WR_LOW     = 12'b0000_0010_0000,
        PH_WR_BODY    = 12'b0000_0100_0000,
        PH_CONV       = 12'b0000_1000_0000,
        PH_RD_LOW     = 12'b0001_0000_0000,
        PH_RD_WAIT    = 12'b0010_0000_0000,
        PH_RD_SAMPLE  = 12'b0100_0000_0000,
        PH_RD_TAIL    = 12'b1000_0000_0000
    } phase_t;

    // command byte sent at each position of the sequence
    function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = CMD_SKIP_ROM;
            2'd1:    b = CMD_CONVERT;
            2'd2:    b = CMD_SKIP_ROM;
            default: b = CMD_READ_SPAD;
        endcase
        return b;
    endfunction

endpackage

// File: hw/rtl/onewire_temperature_read_master_unit.sv
// 1-wire temperature read master, top level; uses owtrm_pkg
// an accepted transaction's result is in the output register from the next cycle
// throughput: one transaction per cycle; input stalls only while a result waits unread
// the sequence and zero-length phase skipping resolve in one pass of phase logic
// reset: sequence idle, timing registers at defaults, no result pending
module onewire_temperature_read_master_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [owtrm_pkg::ADDR_W-1:0]    paddr,
    input  logic [owtrm_pkg::DATA_W-1:0]    pwdata,
    output logic [owtrm_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  owtrm_pkg::req_t                 req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output owtrm_pkg::rsp_t                 rsp
);
    import owtrm_pkg::*;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  bit_idx;
        logic [2:0]  cmd_idx;
        logic [7:0]  wr_shift;
        logic [15:0] rd_word;
        logic        presence;
    } seq_t;

    typedef struct packed {
        seq_t seq;
        logic done;
        logic err;
    } step_t;

    localparam seq_t SEQ_RESET = '{
        phase:    PH_IDLE,
        bit_idx:  4'd0,
        cmd_idx:  3'd0,
        wr_shift: 8'd0,
        rd_word:  16'd0,
        presence: 1'b0
    };

    // ---------------------------------------------------------------
    // phase resolution helpers; each stops at the first phase with
    // nonzero length or at the end of the sequence
    // ---------------------------------------------------------------
    function automatic step_t go_to(input seq_t s, input phase_t p);
        step_t r;
        r.seq       = s;
        r.seq.phase = p;
        r.done      = 1'b0;
        r.err       = 1'b0;
        return r;
    endfunction

    function automatic step_t finish(input seq_t s, input logic err);
        step_t r;
        r       = go_to(s, PH_IDLE);
        r.done  = 1'b1;
        r.err   = err;
        return r;
    endfunction

    function automatic step_t enter_rst(input cfg_t c, input seq_t s);
        seq_t t;
        t          = s;
        t.presence = 1'b0;
        if (c.reset_low != '0)
            return go_to(t, PH_RST_LOW);
        else if (c.presence_wait != '0)
            return go_to(t, PH_RST_WAIT);
        else
            return go_to(t, PH_RST_SAMPLE);
    endfunction

    function automatic step_t enter_rd(input cfg_t c, input seq_t s);
        if (c.slot_start != '0)
            return go_to(s, PH_RD_LOW);
        else if (c.read_sample != '0)
            return go_to(s, PH_RD_WAIT);
        else
            return go_to(s, PH_RD_SAMPLE);
    endfunction

    function automatic step_t enter_conv(input cfg_t c, input seq_t s);
        if (c.conv_wait != '0)
            return go_to(s, PH_CONV);
        else
            return enter_rst(c, s);
    endfunction

    function automatic step_t start_read(input cfg_t c, input seq_t s);
        seq_t t;
        t         = s;
        t.rd_word = '0;
        t.bit_idx = '0;
        return enter_rd(c, t);
    endfunction

    // write slot entry; with both slot times zero the rest of the
    // current command (and a paired command) completes at once
    function automatic step_t enter_wr(input cfg_t c, input seq_t s);
        seq_t       t;
        logic [2:0] last;
        t    = s;
        last = ((s.cmd_idx == 3'd0) || (s.cmd_idx == 3'd2)) ? s.cmd_idx + 3'd1 : s.cmd_idx;
        if (c.slot_start != '0)
            return go_to(t, PH_WR_LOW);
        else if (c.write_slot != '0)
            return go_to(t, PH_WR_BODY);
        else
        begin
            t.cmd_idx  = last + 3'd1;
            t.wr_shift = '0;
            t.bit_idx  = 4'd8;
            if (last == 3'd1)
                return enter_conv(c, t);
            else
                return start_read(c, t);
        end
    endfunction

    function automatic step_t load_cmd(input cfg_t c, input seq_t s);
        seq_t t;
        t          = s;
        t.wr_shift = cmd_byte(s.cmd_idx[1:0]);
        t.bit_idx  = '0;
        return enter_wr(c, t);
    endfunction

    function automatic step_t after_byte(input cfg_t c, input seq_t s);
        seq_t t;
        t         = s;
        t.cmd_idx = s.cmd_idx + 3'd1;
        if (s.cmd_idx == 3'd1)
            return enter_conv(c, t);
        else if (s.cmd_idx >= 3'd3)
            return start_read(c, t);
        else
            return load_cmd(c, t);
    endfunction

    function automatic step_t leave_wr_body(input cfg_t c, input seq_t s);
        seq_t t;
        t          = s;
        t.wr_shift = s.wr_shift >> 1;
        t.bit_idx  = s.bit_idx + 4'd1;
        if (t.bit_idx < 4'd8)
            return enter_wr(c, t);
        else
            return after_byte(c, t);
    endfunction

    function automatic step_t leave_rst_tail(input cfg_t c, input seq_t s);
        if (!s.presence)
            return finish(s, 1'b1);
        else
            return load_cmd(c, s);
    endfunction

    function automatic step_t leave_rd_tail(input cfg_t c, input seq_t s);
        seq_t t;
        t         = s;
        t.bit_idx = s.bit_idx + 4'd1;
        if (s.bit_idx >= 4'd15)
            return finish(s, 1'b0);
        else
            return enter_rd(c, t);
    endfunction

    function automatic step_t leave_phase(input cfg_t c, input seq_t s);
        step_t r;
        case (s.phase)
            PH_RST_LOW:    r = go_to(s, (c.presence_wait != '0) ? PH_RST_WAIT : PH_RST_SAMPLE);
            PH_RST_WAIT:   r = go_to(s, PH_RST_SAMPLE);
            PH_RST_SAMPLE: r = (c.reset_tail > 10'd1) ? go_to(s, PH_RST_TAIL)
                                                      : leave_rst_tail(c, s);
            PH_RST_TAIL:   r = leave_rst_tail(c, s);
            PH_WR_LOW:     r = (c.write_slot != '0) ? go_to(s, PH_WR_BODY)
                                                    : leave_wr_body(c, s);
            PH_WR_BODY:    r = leave_wr_body(c, s);
            PH_CONV:       r = enter_rst(c, s);
            PH_RD_LOW:     r = go_to(s, (c.read_sample != '0) ? PH_RD_WAIT : PH_RD_SAMPLE);
            PH_RD_WAIT:    r = go_to(s, PH_RD_SAMPLE);
            PH_RD_SAMPLE:  r = (c.read_tail > 7'd1) ? go_to(s, PH_RD_TAIL)
                                                    : leave_rd_tail(c, s);
            PH_RD_TAIL:    r = leave_rd_tail(c, s);
            default:       r = finish(s, 1'b0);
        endcase
        return r;
    endfunction

    // ticks spent in a phase before it is left
    function automatic logic [CNT_W-1:0] phase_len(input cfg_t c, input phase_t p);
        logic [CNT_W-1:0] n;
        case (p)
            PH_RST_LOW:   n = CNT_W'(c.reset_low);
            PH_RST_WAIT:  n = CNT_W'(c.presence_wait);
            PH_RST_TAIL:  n = (c.reset_tail != '0) ? CNT_W'(c.reset_tail - 10'd1) : '0;
            PH_WR_LOW:    n = CNT_W'(c.slot_start);
            PH_WR_BODY:   n = CNT_W'(c.write_slot);
            PH_CONV:      n = c.conv_wait;
            PH_RD_LOW:    n = CNT_W'(c.slot_start);
            PH_RD_WAIT:   n = CNT_W'(c.read_sample);
            PH_RD_TAIL:   n = (c.read_tail != '0) ? CNT_W'(c.read_tail - 7'd1) : '0;
            default:      n = CNT_W'(1);
        endcase
        return n;
    endfunction

    // open-drain drive level of a phase
    function automatic logic drive_of(input seq_t s);
        logic d;
        case (s.phase)
            PH_RST_LOW,
            PH_WR_LOW,
            PH_RD_LOW:  d = 1'b1;
            PH_WR_BODY: d = ~s.wr_shift[0];
            default:    d = 1'b0;
        endcase
        return d;
    endfunction

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    cfg_t             cfg_reg;
    seq_t             seq_reg, seq_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             accept;
    logic             cfg_wr;
    reg_idx_t         cfg_idx;

    // handshake: output register frees when taken
    assign req_ready      = !rsp_valid_reg || rsp_ready;
    assign accept         = req_valid && req_ready;
    assign rsp_valid_next = accept || (rsp_valid_reg && !rsp_ready);
    assign rsp_valid      = rsp_valid_reg;
    assign rsp            = rsp_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    // register read mux
    always_comb
    begin
        case (cfg_idx)
            REG_RESET_LOW:     prdata = DATA_W'(cfg_reg.reset_low);
            REG_PRESENCE_WAIT: prdata = DATA_W'(cfg_reg.presence_wait);
            REG_RESET_TAIL:    prdata = DATA_W'(cfg_reg.reset_tail);
            REG_CONV_WAIT:     prdata = DATA_W'(cfg_reg.conv_wait);
            REG_SLOT_START:    prdata = DATA_W'(cfg_reg.slot_start);
            REG_WRITE_SLOT:    prdata = DATA_W'(cfg_reg.write_slot);
            REG_READ_SAMPLE:   prdata = DATA_W'(cfg_reg.read_sample);
            REG_READ_TAIL:     prdata = DATA_W'(cfg_reg.read_tail);
            default:           prdata = '0;
        endcase
    end

    // timing register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_wr && pready)
        begin
            case (cfg_idx)
                REG_RESET_LOW:     cfg_reg.reset_low     <= pwdata[9:0];
                REG_PRESENCE_WAIT: cfg_reg.presence_wait <= pwdata[7:0];
                REG_RESET_TAIL:    cfg_reg.reset_tail    <= pwdata[9:0];
                REG_CONV_WAIT:     cfg_reg.conv_wait     <= pwdata[CNT_W-1:0];
                REG_SLOT_START:    cfg_reg.slot_start    <= pwdata[3:0];
                REG_WRITE_SLOT:    cfg_reg.write_slot    <= pwdata[6:0];
                REG_READ_SAMPLE:   cfg_reg.read_sample   <= pwdata[5:0];
                REG_READ_TAIL:     cfg_reg.read_tail     <= pwdata[6:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // sequence step for one transaction
    always_comb
    begin
        seq_t             s;
        step_t            st;
        logic [CNT_W-1:0] cnt_inc;
        logic             drive;

        s        = seq_reg;
        st       = go_to(seq_reg, seq_reg.phase);
        cnt_inc  = cnt_reg + CNT_W'(1);
        cnt_next = cnt_reg;
        drive    = 1'b0;

        if (req.kind == KIND_START)
        begin
            if (seq_reg.phase == PH_IDLE)
            begin
                s          = SEQ_RESET;
                st         = enter_rst(cfg_reg, s);
                cnt_next   = '0;
            end
            drive = drive_of(st.seq);
        end
        else if (seq_reg.phase != PH_IDLE)
        begin
            drive = drive_of(seq_reg);
            // bus sampling
            if (seq_reg.phase == PH_RST_SAMPLE)
                s.presence = ~req.line_in;
            else if ((seq_reg.phase == PH_RD_SAMPLE) && req.line_in)
                s.rd_word[seq_reg.bit_idx] = 1'b1;
            if (cnt_inc >= phase_len(cfg_reg, seq_reg.phase))
            begin
                st       = leave_phase(cfg_reg, s);
                cnt_next = '0;
            end
            else
            begin
                st       = go_to(s, s.phase);
                cnt_next = cnt_inc;
            end
        end

        seq_next             = st.seq;
        rsp_next.drive_low   = drive;
        rsp_next.busy_res    = (st.seq.phase != PH_IDLE);
        rsp_next.done_res    = st.done;
        rsp_next.no_device   = st.done && st.err;
        rsp_next.temperature = (st.done && !st.err) ? st.seq.rd_word[15:4] : 12'd0;
    end

    // sequence state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= SEQ_RESET;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                seq_reg <= seq_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// File: hw/rtl/owtrm_chk.sv
// port-level checker for the 1-wire temperature read master, bound to the top level
// depends on owtrm_pkg and onewire_temperature_read_master_unit_assert.svh
`include "onewire_temperature_read_master_unit_assert.svh"

module owtrm_chk (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input owtrm_pkg::rsp_t                 rsp
);

    // a completing transaction leaves the master idle
    `OWTRM_ASSERT_NOW(a_done_not_busy, rsp_valid && rsp.done_res, !rsp.busy_res,
        "done reported while still busy")

    // missing device and a temperature only come with done
    `OWTRM_ASSERT_NOW(a_result_only_on_done, rsp_valid && !rsp.done_res,
        !rsp.no_device && (rsp.temperature == 12'd0),
        "result fields set without done")

    // the bus is released whenever no sequence runs
    `OWTRM_ASSERT_NOW(a_idle_released, rsp_valid && !rsp.busy_res, !rsp.drive_low,
        "bus driven low while idle")

    // a stalled result holds
    `OWTRM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp),
        "result changed while stalled")

endmodule

bind onewire_temperature_read_master_unit owtrm_chk u_owtrm_chk (.*);
